FILE: rtl/sawip_pkg.sv
// ----------------------------------------------------------------------------
// sawip_pkg - shared types and codes for the stop-and-wait image push sender
// Command, reply, event and phase codes, sequencer states, field widths.
// ----------------------------------------------------------------------------
package sawip_pkg;

  localparam int BYTE_W    = 24;  // image sizes and offsets
  localparam int SESS_W    = 32;
  localparam int LEN_W     = 8;
  localparam int TIMER_W   = 16;
  localparam int TRIES_W   = 8;
  localparam int CFG_IDX_W = 2;
  localparam int CFG_DAT_W = 16;

  // progress divider: quotient never exceeds 100, so seven bits
  localparam int PCT_W     = 7;
  localparam int DIV_STEPS = PCT_W;
  localparam int STEP_W    = 3;
  localparam int REM_W     = BYTE_W + PCT_W;

  localparam logic [TIMER_W-1:0] TIMEOUT_RESET = 16'd600;
  localparam logic [TRIES_W-1:0] TRIES_RESET   = 8'd10;

  localparam logic [CFG_IDX_W-1:0] REG_TIMEOUT = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_TRIES   = 2'd1;

  localparam logic [1:0] CMD_START = 2'd0;
  localparam logic [1:0] CMD_REPLY = 2'd1;
  localparam logic [1:0] CMD_TICK  = 2'd2;

  localparam logic [2:0] ST_READY = 3'd0;
  localparam logic [2:0] ST_OK    = 3'd1;
  localparam logic [2:0] ST_NEED  = 3'd2;
  localparam logic [2:0] ST_ERR   = 3'd3;
  localparam logic [2:0] ST_DONE  = 3'd4;

  localparam logic [2:0] EV_BEGIN = 3'd0;
  localparam logic [2:0] EV_DATA  = 3'd1;
  localparam logic [2:0] EV_END   = 3'd2;
  localparam logic [2:0] EV_OK    = 3'd3;
  localparam logic [2:0] EV_FAIL  = 3'd4;

  typedef enum logic [1:0] {
    PH_IDLE  = 2'd0,
    PH_BEGIN = 2'd1,
    PH_DATA  = 2'd2,
    PH_END   = 2'd3
  } phase_t;

  typedef enum logic [1:0] {
    SEQ_WAIT = 2'd0,
    SEQ_DIV  = 2'd1,
    SEQ_PUSH = 2'd2
  } seq_state_t;

endpackage

FILE: rtl/sawip_if.sv
// ----------------------------------------------------------------------------
// sawip_if - channel interfaces of the image push sender
// Input item channel, result channel and configuration write channel.
// ----------------------------------------------------------------------------
interface sawip_item_if;
  logic        valid;
  logic        ready;
  logic [1:0]  cmd;
  logic [23:0] image_size;
  logic [31:0] reply_session;
  logic [2:0]  reply_state;
  logic [31:0] reply_next_offset;

  modport source (output valid, cmd, image_size, reply_session, reply_state,
                  reply_next_offset, input ready);
  modport sink   (input valid, cmd, image_size, reply_session, reply_state,
                  reply_next_offset, output ready);
endinterface

interface sawip_result_if;
  logic              valid;
  logic              ready;
  logic [2:0]        event_kind;
  logic [31:0]       session_num;
  logic [23:0]       frame_offset;
  logic [7:0]        frame_length;
  logic [23:0]       total_bytes;
  logic signed [7:0] progress_pct;

  modport source (output valid, event_kind, session_num, frame_offset,
                  frame_length, total_bytes, progress_pct, input ready);
  modport sink   (input valid, event_kind, session_num, frame_offset,
                  frame_length, total_bytes, progress_pct, output ready);
endinterface

interface sawip_cfg_if;
  logic        valid;
  logic        ready;
  logic [1:0]  index;
  logic [15:0] data;

  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface

FILE: rtl/sawip_div.sv
// ----------------------------------------------------------------------------
// sawip_div - serial progress divider
// Computes num*100/den by restoring division, one quotient bit a cycle.
// ----------------------------------------------------------------------------
module sawip_div import sawip_pkg::*; (
  input  logic              clk,
  input  logic              rst,
  input  logic              start,
  input  logic [BYTE_W-1:0] num,
  input  logic [BYTE_W-1:0] den,
  output logic              done,
  output logic [PCT_W-1:0]  quot
);

  logic              busy;
  logic [STEP_W-1:0] cnt;
  logic [REM_W-1:0]  rem;
  logic [REM_W-1:0]  dsh;
  logic [REM_W-1:0]  num_w;
  logic              ge;

  assign num_w = REM_W'(num);
  assign ge    = (rem >= dsh);

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        cnt  <= '0;
      end else if (busy) begin
        cnt <= cnt + 1'b1;
        if (cnt == STEP_W'(DIV_STEPS - 1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  // x100 as 64 + 32 + 4, then the divisor walks down from its top alignment
  always_ff @(posedge clk) begin
    if (start) begin
      rem  <= (num_w << 6) + (num_w << 5) + (num_w << 2);
      dsh  <= REM_W'(den) << (DIV_STEPS - 1);
      quot <= '0;
    end else if (busy) begin
      if (ge) begin
        rem <= rem - dsh;
      end
      quot <= {quot[PCT_W-2:0], ge};
      dsh  <= dsh >> 1;
    end
  end

endmodule

FILE: rtl/stop_and_wait_image_push.sv
// ----------------------------------------------------------------------------
// stop_and_wait_image_push - sender sequencer for a stop-and-wait image push
// Begin, data and end frames with per-try timeout, retry and progress.
// ----------------------------------------------------------------------------
// Use:
//   item   : one word per event - start (with image size), status reply
//            (session, state, next offset) or a one millisecond tick.
//   result : at most one word per item - a frame to send (begin, data, end)
//            or the end of the transfer (ok or failed), with the session,
//            chunk offset and length, image size and progress percent.
//   cfg    : register writes (0 timeout ticks, 1 max tries), always ready;
//            write only while the block is quiet.
// Sequence: item ready only while the sequencer waits. An item that gives no
//   word leaves the sequencer waiting. One that gives a word passes to a push
//   state, which loads the output register; an accepted data reply first runs
//   the serial divider for the progress percent, 7 steps, and waits for its
//   done flag.
// Stall: the result sits in an output register; the next item is taken
//   while it waits, and a further word is held until the register frees.
// Reset: idle, session counter zero, progress -1, timeout 600, tries 10.
// ----------------------------------------------------------------------------
module stop_and_wait_image_push import sawip_pkg::*; #(
  parameter int CHUNK_BYTES = 200
) (
  input  logic clk,
  input  logic rst,
  sawip_item_if.sink     item,
  sawip_result_if.source result,
  sawip_cfg_if.sink      cfg
);

  localparam logic [BYTE_W-1:0] CHUNK = BYTE_W'(CHUNK_BYTES);

  // transfer state
  phase_t             phase, phase_next;
  logic [SESS_W-1:0]  sess, sess_next;
  logic [BYTE_W-1:0]  offset, offset_next;
  logic [BYTE_W-1:0]  total, total_next;
  logic [TRIES_W-1:0] tries, tries_next;
  logic [TIMER_W-1:0] timer, timer_next;
  logic [7:0]         pct, pct_next;

  // config
  logic [TIMER_W-1:0] timeout_ticks;
  logic [TRIES_W-1:0] max_tries;

  // sequencer
  seq_state_t seq, seq_next;
  logic       take;
  logic       load;
  logic       div_go;
  logic       div_done;
  logic [PCT_W-1:0] div_q;

  // pending word
  logic [2:0]        pend_kind, kind_next;
  logic [BYTE_W-1:0] pend_off, foff_next;
  logic [LEN_W-1:0]  pend_len, flen_next;

  // decode scratch
  logic               emit_frame, emit_fin, do_retry, do_adv, need_div;
  logic [2:0]         fin_kind;
  logic [TRIES_W-1:0] limit;
  logic [TIMER_W-1:0] timer_inc;
  logic [BYTE_W-1:0]  taken, left, chunk_n;
  logic               emit;

  assign take      = item.valid && item.ready;
  assign limit     = (max_tries == '0) ? TRIES_W'(1) : max_tries;
  assign timer_inc = timer + 1'b1;
  // worker's offset, clamped to the image
  assign taken = (item.reply_next_offset >= 32'(total)) ? total
                                                        : item.reply_next_offset[BYTE_W-1:0];

  // ---- item decode ----
  always_comb begin
    phase_next  = phase;
    sess_next   = sess;
    offset_next = offset;
    total_next  = total;
    tries_next  = tries;
    timer_next  = timer;
    pct_next    = pct;
    emit_frame  = 1'b0;
    emit_fin    = 1'b0;
    do_retry    = 1'b0;
    do_adv      = 1'b0;
    need_div    = 1'b0;
    fin_kind    = EV_FAIL;

    case (item.cmd)
      CMD_START: begin
        if (phase == PH_IDLE && item.image_size != '0) begin
          sess_next   = sess + 1'b1;
          total_next  = item.image_size;
          offset_next = '0;
          pct_next    = '0;
          phase_next  = PH_BEGIN;
          tries_next  = TRIES_W'(1);
          timer_next  = '0;
          emit_frame  = 1'b1;
        end
      end
      CMD_TICK: begin
        if (phase != PH_IDLE) begin
          timer_next = timer_inc;
          if (timer_inc >= timeout_ticks) begin
            do_retry = 1'b1;
          end
        end
      end
      CMD_REPLY: begin
        if (phase != PH_IDLE && item.reply_session == sess) begin
          if (item.reply_state == ST_ERR) begin
            emit_fin = 1'b1;
            fin_kind = EV_FAIL;
          end else begin
            case (phase)
              PH_BEGIN: begin
                if (item.reply_state == ST_READY || item.reply_state == ST_NEED) begin
                  offset_next = taken;
                  do_adv      = 1'b1;
                end else begin
                  do_retry = 1'b1;
                end
              end
              PH_DATA: begin
                if (item.reply_state == ST_OK || item.reply_state == ST_NEED) begin
                  offset_next = taken;
                  do_adv      = 1'b1;
                  need_div    = 1'b1;
                end else begin
                  do_retry = 1'b1;
                end
              end
              PH_END: begin
                if (item.reply_state == ST_DONE) begin
                  emit_fin = 1'b1;
                  fin_kind = EV_OK;
                end else if (item.reply_state == ST_NEED) begin
                  emit_fin = 1'b1;
                  fin_kind = EV_FAIL;
                end else begin
                  do_retry = 1'b1;
                end
              end
              default: ;
            endcase
          end
        end
      end
      default: ;
    endcase

    // tries run out: end phase counts as done, as the worker has rebooted
    if (do_retry) begin
      if (tries >= limit) begin
        emit_fin = 1'b1;
        fin_kind = (phase == PH_END) ? EV_OK : EV_FAIL;
      end else begin
        tries_next = tries + 1'b1;
        timer_next = '0;
        emit_frame = 1'b1;
      end
    end

    if (do_adv) begin
      phase_next = (offset_next < total) ? PH_DATA : PH_END;
      tries_next = TRIES_W'(1);
      timer_next = '0;
      emit_frame = 1'b1;
    end

    if (emit_fin) begin
      phase_next = PH_IDLE;
      pct_next   = 8'hFF;
      timer_next = '0;
    end
  end

  // ---- frame fields of the word to send ----
  assign left    = total_next - offset_next;
  assign chunk_n = (left > CHUNK) ? CHUNK : left;
  assign emit    = emit_frame || emit_fin;

  always_comb begin
    kind_next = fin_kind;
    foff_next = '0;
    flen_next = '0;
    if (!emit_fin) begin
      case (phase_next)
        PH_BEGIN: kind_next = EV_BEGIN;
        PH_DATA: begin
          kind_next = EV_DATA;
          foff_next = offset_next;
          flen_next = chunk_n[LEN_W-1:0];
        end
        default: kind_next = EV_END;
      endcase
    end
  end

  // ---- sequencer: next state ----
  always_comb begin
    seq_next = seq;
    case (seq)
      SEQ_WAIT: begin
        if (take && emit) begin
          seq_next = need_div ? SEQ_DIV : SEQ_PUSH;
        end
      end
      SEQ_DIV: begin
        if (div_done) begin
          seq_next = SEQ_PUSH;
        end
      end
      SEQ_PUSH: begin
        if (!result.valid || result.ready) begin
          seq_next = SEQ_WAIT;
        end
      end
      default: seq_next = SEQ_WAIT;
    endcase
  end

  // ---- sequencer: outputs ----
  always_comb begin
    item.ready = 1'b0;
    load       = 1'b0;
    div_go     = 1'b0;
    case (seq)
      SEQ_WAIT: begin
        item.ready = 1'b1;
        div_go     = take && emit && need_div;
      end
      SEQ_PUSH: load = !result.valid || result.ready;
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      seq <= SEQ_WAIT;
    end else begin
      seq <= seq_next;
    end
  end

  // ---- transfer state ----
  always_ff @(posedge clk) begin
    if (rst) begin
      phase  <= PH_IDLE;
      sess   <= '0;
      offset <= '0;
      total  <= '0;
      tries  <= '0;
      timer  <= '0;
      pct    <= 8'hFF;
    end else if (take) begin
      phase  <= phase_next;
      sess   <= sess_next;
      offset <= offset_next;
      total  <= total_next;
      tries  <= tries_next;
      timer  <= timer_next;
      pct    <= pct_next;
    end else if (seq == SEQ_DIV && div_done) begin
      pct <= {1'b0, div_q};
    end
  end

  always_ff @(posedge clk) begin
    if (take && emit) begin
      pend_kind <= kind_next;
      pend_off  <= foff_next;
      pend_len  <= flen_next;
    end
  end

  // ---- progress divider ----
  sawip_div u_div (
    .clk   (clk),
    .rst   (rst),
    .start (div_go),
    .num   (offset_next),
    .den   (total_next),
    .done  (div_done),
    .quot  (div_q)
  );

  // ---- output register ----
  always_ff @(posedge clk) begin
    if (rst) begin
      result.valid <= 1'b0;
    end else if (load) begin
      result.valid <= 1'b1;
    end else if (result.ready) begin
      result.valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      result.event_kind   <= pend_kind;
      result.session_num  <= sess;
      result.frame_offset <= pend_off;
      result.frame_length <= pend_len;
      result.total_bytes  <= total;
      result.progress_pct <= pct;
    end
  end

  // ---- config registers ----
  assign cfg.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      timeout_ticks <= TIMEOUT_RESET;
      max_tries     <= TRIES_RESET;
    end else if (cfg.valid && cfg.ready) begin
      case (cfg.index)
        REG_TIMEOUT: timeout_ticks <= cfg.data;
        REG_TRIES:   max_tries     <= cfg.data[TRIES_W-1:0];
        default: ;
      endcase
    end
  end

endmodule
